// ===== design/abld_pkg.sv =====
// shared types and constants for the accelerometer bias and launch detector
`default_nettype none
package abld_pkg;

  // fixed widths of the result fields, the configuration registers and the register index
  localparam int unsigned OUT_W  = 21;
  localparam int unsigned THR_W  = 21;
  localparam int unsigned CONF_W = 4;
  localparam int unsigned CAL_W  = 5;
  localparam int unsigned IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_CONFIRM   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CALIB     = 2'd2;

  // reset values; threshold is two g at 8 fraction bits, rounded
  localparam logic [THR_W-1:0]  THR_RESET  = 21'd5021;
  localparam logic [CONF_W-1:0] CONF_RESET = 4'd3;
  localparam logic [CAL_W-1:0]  CAL_RESET  = 5'd20;

  localparam logic [CONF_W-1:0] EXCEED_MAX = 4'd15;
  localparam logic [OUT_W-1:0]  MAG_MAX    = 21'h1fffff;

  typedef enum logic [1:0] {
    FS_IDLE    = 2'd0,
    FS_ASCEND  = 2'd1,
    FS_DESCEND = 2'd2,
    FS_LANDED  = 2'd3
  } flight_e;

  // status one lane hands to the merge stage
  typedef struct packed {
    logic             done;
    logic             ready;
    logic [OUT_W-1:0] mag;
  } lane_stat_t;

endpackage
`default_nettype wire

// ===== design/accel_bias_launch_detector_core.sv =====
// top level: stream ports, config registers, two sensor lanes and the merge stage
// steps: a word that is summed into the bias, or one from an invalid sensor, goes straight
//   to the lane done state; the word that forms the bias runs a bit-serial divider over the
//   sum width; once calibrated, three squares share one multiplier, then the square root
//   gives one digit a cycle
// handshake: one word at a time; the slower lane holds the load, and the next word is only
//   taken once the result is in the output register, which waits while a held result has
//   not yet been taken on m_axis_tready
// reset: asynchronous, active low; clears registers to their reset values, sums, counts,
//   calibration flags, magnitudes and the flight state (idle)
`default_nettype none
module accel_bias_launch_detector_core #(
  parameter int unsigned SAMPLE_WIDTH = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input words
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // prim_x, prim_y, prim_z, back_x, back_y, back_z
  input  wire logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // prim_valid, back_valid
  input  wire logic [1:0]                           s_axis_tuser,
  // result words
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // prim_x_out, prim_y_out, prim_z_out, back_x_out, back_y_out, back_z_out,
  // prim_magnitude, back_magnitude
  output logic [167:0]                              m_axis_tdata,
  // prim_calibrated, back_calibrated, flight_state
  output logic [3:0]                                m_axis_tuser,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [abld_pkg::IDX_W-1:0]           cfg_idx_i,
  input  wire logic [abld_pkg::THR_W-1:0]           cfg_data_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;

  // configuration registers
  logic [abld_pkg::THR_W-1:0]  thr_q;
  logic [abld_pkg::CONF_W-1:0] conf_q;
  logic [abld_pkg::CAL_W-1:0]  cal_q;

  // control
  logic busy_q;
  logic pv_q, bv_q;
  logic accept, load;

  logic signed [SW-1:0]              prim_smp [3];
  logic signed [SW-1:0]              back_smp [3];
  logic signed [abld_pkg::OUT_W-1:0] prim_axes [3];
  logic signed [abld_pkg::OUT_W-1:0] back_axes [3];
  abld_pkg::lane_stat_t              prim_stat, back_stat;
  abld_pkg::flight_e                 phase_d;

  logic         m_valid_q;
  logic [167:0] m_data_q;
  logic [3:0]   m_user_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prim_smp[k] = s_axis_tdata[k*SW +: SW];
      back_smp[k] = s_axis_tdata[(k+3)*SW +: SW];
    end
  end

  // one word in flight; the output register frees the input side
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;
  assign load          = busy_q && prim_stat.done && back_stat.done &&
                         (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= abld_pkg::THR_RESET;
      conf_q <= abld_pkg::CONF_RESET;
      cal_q  <= abld_pkg::CAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abld_pkg::REG_THRESHOLD: thr_q  <= cfg_data_i;
        abld_pkg::REG_CONFIRM:   conf_q <= cfg_data_i[abld_pkg::CONF_W-1:0];
        abld_pkg::REG_CALIB:     cal_q  <= cfg_data_i[abld_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pv_q      <= 1'b0;
      bv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        pv_q   <= s_axis_tuser[0];
        bv_q   <= s_axis_tuser[1];
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {back_stat.mag, prim_stat.mag,
                   back_axes[2], back_axes[1], back_axes[0],
                   prim_axes[2], prim_axes[1], prim_axes[0]};
      m_user_q <= {phase_d, back_stat.ready, prim_stat.ready};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // primary lane
  abld_lane #(.SW(SW)) u_prim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .valid_i   (s_axis_tuser[0]),
    .smp_i     (prim_smp),
    .calib_n_i (cal_q),
    .ack_i     (load),
    .stat_o    (prim_stat),
    .axes_o    (prim_axes)
  );

  // backup lane
  abld_lane #(.SW(SW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .valid_i   (s_axis_tuser[1]),
    .smp_i     (back_smp),
    .calib_n_i (cal_q),
    .ack_i     (load),
    .stat_o    (back_stat),
    .axes_o    (back_axes)
  );

  // merge: launch detection on the chosen magnitude
  abld_launch u_launch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (load),
    .pv_i      (pv_q),
    .bv_i      (bv_q),
    .prim_i    (prim_stat),
    .back_i    (back_stat),
    .thr_i     (thr_q),
    .conf_i    (conf_q),
    .phase_d_o (phase_d)
  );

`ifndef SYNTHESIS
  // a lane only finishes for a word that was taken
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prim_stat.done || back_stat.done) |-> busy_q)
    else $error("lane done without a word in flight");

  // calibration is never lost
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prim_stat.ready && back_stat.ready) |=> (prim_stat.ready && back_stat.ready))
    else $error("calibration flag dropped");

  // once launched, the flight state is held in every result
  a_ascend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && phase_d == abld_pkg::FS_ASCEND) |=> (phase_d == abld_pkg::FS_ASCEND))
    else $error("flight state left ascend");

  // no new word is taken while a result has not been loaded
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !load) |=> busy_q)
    else $error("word in flight lost");
`endif

endmodule
`default_nettype wire

// ===== design/abld_lane.sv =====
// one sensor lane: bias accumulation, bias division, subtraction and magnitude
`default_nettype none
module abld_lane #(
  parameter int unsigned SW = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic                               valid_i,
  input  wire logic signed [SW-1:0]               smp_i [3],
  input  wire logic [abld_pkg::CAL_W-1:0]         calib_n_i,
  input  wire logic                               ack_i,
  output abld_pkg::lane_stat_t                    stat_o,
  output logic signed [abld_pkg::OUT_W-1:0]       axes_o [3]
);

  localparam int unsigned OW   = abld_pkg::OUT_W;
  localparam int unsigned CW   = abld_pkg::CAL_W;
  localparam int unsigned SUMW = SW + CW;
  localparam int unsigned DW   = SW + 1;
  localparam int unsigned SQW  = 2 * DW + 2;
  localparam int unsigned RW   = SQW / 2;
  localparam int unsigned CMPW = (RW > OW) ? RW : OW;
  localparam int unsigned STW  = $clog2(((SUMW > RW) ? SUMW : RW) + 1);

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIV,
    L_SQ,
    L_ROOT,
    L_DONE
  } lane_state_e;

  lane_state_e              state_q;
  logic signed [SUMW-1:0]   sum_q  [3];
  logic [SUMW-1:0]          dquo_q [3];
  logic [CW:0]              drem_q [3];
  logic                     dneg_q [3];
  logic signed [DW-1:0]     dif_q  [3];
  logic [CW-1:0]            cnt_q;
  logic                     rdy_q;
  logic [OW-1:0]            mag_q;
  logic signed [OW-1:0]     axes_q [3];
  logic [SQW-1:0]           acc_q;
  logic [SQW-1:0]           rn_q;
  logic [RW-1:0]            rt_q;
  logic [RW+1:0]            rr_q;
  logic [STW-1:0]           step_q;

  logic [CW-1:0]            n_eff;
  logic [SUMW-1:0]          dquo_d [3];
  logic [CW:0]              drem_d [3];
  logic [DW-1:0]            sq_abs;
  logic [SQW-1:0]           acc_d;
  logic [RW+1:0]            rr_sh;
  logic [RW+1:0]            rr_trial;
  logic [RW+1:0]            rr_d;
  logic [RW-1:0]            rt_d;
  logic [OW-1:0]            mag_d;

  assign n_eff = (calib_n_i == '0) ? CW'(1) : calib_n_i;

  // one restoring division step per axis
  always_comb begin
    logic [CW+1:0] t;
    for (int k = 0; k < 3; k++) begin
      t = {drem_q[k], dquo_q[k][SUMW-1]};
      if (t >= {2'b00, cnt_q}) begin
        drem_d[k] = (CW+1)'(t - {2'b00, cnt_q});
        dquo_d[k] = {dquo_q[k][SUMW-2:0], 1'b1};
      end else begin
        drem_d[k] = (CW+1)'(t);
        dquo_d[k] = {dquo_q[k][SUMW-2:0], 1'b0};
      end
    end
  end

  // one square per cycle through a shared multiplier
  always_comb begin
    logic signed [DW-1:0] dsel;
    logic [2*DW-1:0]      sq;
    case (step_q[1:0])
      2'd0:    dsel = dif_q[0];
      2'd1:    dsel = dif_q[1];
      default: dsel = dif_q[2];
    endcase
    sq_abs = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
    sq     = sq_abs * sq_abs;
    acc_d  = acc_q + SQW'(sq);
  end

  // one digit pair of the square root per cycle
  always_comb begin
    rr_sh    = {rr_q[RW-1:0], rn_q[SQW-1:SQW-2]};
    rr_trial = {rt_q, 2'b01};
    if (rr_sh >= rr_trial) begin
      rr_d = rr_sh - rr_trial;
      rt_d = {rt_q[RW-2:0], 1'b1};
    end else begin
      rr_d = rr_sh;
      rt_d = {rt_q[RW-2:0], 1'b0};
    end
    mag_d = (CMPW'(rt_d) > CMPW'(abld_pkg::MAG_MAX)) ? abld_pkg::MAG_MAX : OW'(rt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      rdy_q   <= 1'b0;
      mag_q   <= '0;
      step_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            if (!valid_i) begin
              for (int k = 0; k < 3; k++) axes_q[k] <= '0;
              state_q <= L_DONE;
            end else if (!rdy_q) begin
              for (int k = 0; k < 3; k++) axes_q[k] <= OW'(smp_i[k]);
              if (cnt_q < n_eff) begin
                for (int k = 0; k < 3; k++) sum_q[k] <= sum_q[k] + SUMW'(smp_i[k]);
                cnt_q   <= cnt_q + CW'(1);
                state_q <= L_DONE;
              end else begin
                for (int k = 0; k < 3; k++) begin
                  dneg_q[k] <= sum_q[k][SUMW-1];
                  dquo_q[k] <= sum_q[k][SUMW-1] ? SUMW'(-sum_q[k]) : SUMW'(sum_q[k]);
                  drem_q[k] <= '0;
                end
                step_q  <= STW'(SUMW);
                state_q <= L_DIV;
              end
            end else begin
              for (int k = 0; k < 3; k++) begin
                dif_q[k]  <= DW'(smp_i[k]) - DW'(sum_q[k]);
                axes_q[k] <= OW'(DW'(smp_i[k]) - DW'(sum_q[k]));
              end
              acc_q   <= '0;
              step_q  <= '0;
              state_q <= L_SQ;
            end
          end
        end
        L_DIV: begin
          for (int k = 0; k < 3; k++) begin
            dquo_q[k] <= dquo_d[k];
            drem_q[k] <= drem_d[k];
          end
          step_q <= step_q - STW'(1);
          if (step_q == STW'(1)) begin
            for (int k = 0; k < 3; k++) begin
              sum_q[k] <= dneg_q[k] ? SUMW'(-dquo_d[k]) : SUMW'(dquo_d[k]);
            end
            rdy_q   <= 1'b1;
            state_q <= L_DONE;
          end
        end
        L_SQ: begin
          acc_q <= acc_d;
          if (step_q == STW'(2)) begin
            rn_q    <= acc_d;
            rt_q    <= '0;
            rr_q    <= '0;
            step_q  <= STW'(RW);
            state_q <= L_ROOT;
          end else begin
            step_q <= step_q + STW'(1);
          end
        end
        L_ROOT: begin
          rn_q   <= {rn_q[SQW-3:0], 2'b00};
          rt_q   <= rt_d;
          rr_q   <= rr_d;
          step_q <= step_q - STW'(1);
          if (step_q == STW'(1)) begin
            mag_q   <= mag_d;
            state_q <= L_DONE;
          end
        end
        L_DONE: begin
          if (ack_i) state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign stat_o.done  = (state_q == L_DONE);
  assign stat_o.ready = rdy_q;
  assign stat_o.mag   = mag_q;
  assign axes_o       = axes_q;

endmodule
`default_nettype wire

// ===== design/abld_launch.sv =====
// merge stage: picks a lane magnitude and runs the launch detector
`default_nettype none
module abld_launch (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          upd_i,
  input  wire logic                          pv_i,
  input  wire logic                          bv_i,
  input  abld_pkg::lane_stat_t               prim_i,
  input  abld_pkg::lane_stat_t               back_i,
  input  wire logic [abld_pkg::THR_W-1:0]    thr_i,
  input  wire logic [abld_pkg::CONF_W-1:0]   conf_i,
  output abld_pkg::flight_e                  phase_d_o
);

  abld_pkg::flight_e               phase_q, phase_d;
  logic [abld_pkg::CONF_W-1:0]     cnt_q, cnt_d;

  always_comb begin
    logic [abld_pkg::OUT_W-1:0]  mag;
    logic [abld_pkg::CONF_W-1:0] inc;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    mag     = pv_i ? prim_i.mag : back_i.mag;
    inc     = (cnt_q < abld_pkg::EXCEED_MAX) ? cnt_q + 4'd1 : cnt_q;
    if (upd_i && phase_q == abld_pkg::FS_IDLE && (pv_i || bv_i) && mag > thr_i) begin
      if (inc >= conf_i) begin
        phase_d = abld_pkg::FS_ASCEND;
        cnt_d   = '0;
      end else begin
        cnt_d = inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= abld_pkg::FS_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign phase_d_o = phase_d;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the accelerometer bias removal and launch detector
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 20;
  localparam int DW = ((6*SW+7)/8)*8;
  localparam int WATCHDOG = 20000;   // idle cycles with no word moving on either side

  // one input word as the block sees it
  typedef struct {
    logic          pv;
    logic          bv;
    logic [SW-1:0] ax[6];           // prim x,y,z then back x,y,z
  } sample_t;

  // one result word, split into its fields
  typedef struct {
    logic [abld_pkg::OUT_W-1:0] axis_out[6];
    logic [abld_pkg::OUT_W-1:0] pmag;
    logic [abld_pkg::OUT_W-1:0] bmag;
    logic                       pcal;
    logic                       bcal;
    abld_pkg::flight_e          fs;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [abld_pkg::IDX_W-1:0] cfg_idx_i = abld_pkg::REG_THRESHOLD;
  logic [abld_pkg::THR_W-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  accel_bias_launch_detector_core #(.SAMPLE_WIDTH(SW)) DUT (.*);

  // predictor state, mirrors the block
  logic [abld_pkg::THR_W-1:0]  thr_q;
  logic [abld_pkg::CONF_W-1:0] conf_q;
  logic [abld_pkg::CAL_W-1:0]  cal_q;
  longint                      bias_acc[6];
  int unsigned                 n_summed[2];
  bit                          calibrated[2];
  logic [abld_pkg::OUT_W-1:0]  mag_q[2];
  int unsigned                 hits;
  abld_pkg::flight_e           phase_q;

  sample_t pending_samples[$];
  result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned words_in = 0, words_out = 0, launches = 0;
  int unsigned idle_cycles = 0;
  int unsigned max_gap = 3;         // sender gap ceiling, varied by phase
  int unsigned gap_left = 0;
  bit s_axis_tready_seen = 1'b0;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // advances one sensor lane and fills its three axis outputs
  function automatic void advance_lane(input int s, input logic vld, input sample_t it,
                                       inout result_t r);
    longint v[3];
    longint d;
    longint unsigned sq;
    int unsigned lim;
    sq = 0;
    lim = (cal_q == 0) ? 1 : cal_q;
    if (!vld) begin
      for (int k = 0; k < 3; k++) r.axis_out[s*3+k] = '0;
      return;
    end
    for (int k = 0; k < 3; k++) v[k] = longint'($signed(it.ax[s*3+k]));
    if (!calibrated[s]) begin
      if (n_summed[s] < lim) begin
        for (int k = 0; k < 3; k++) bias_acc[s*3+k] += v[k];
        n_summed[s]++;
      end else begin
        // sv division truncates toward zero, as the block does
        for (int k = 0; k < 3; k++)
          bias_acc[s*3+k] = bias_acc[s*3+k] / longint'(n_summed[s]);
        calibrated[s] = 1'b1;
      end
      for (int k = 0; k < 3; k++) r.axis_out[s*3+k] = v[k][abld_pkg::OUT_W-1:0];
      return;
    end
    for (int k = 0; k < 3; k++) begin
      d = v[k] - bias_acc[s*3+k];
      r.axis_out[s*3+k] = d[abld_pkg::OUT_W-1:0];
      sq += longint'(d * d);
    end
    sq = floor_root(sq);
    mag_q[s] = (sq > abld_pkg::MAG_MAX) ? abld_pkg::MAG_MAX : sq[abld_pkg::OUT_W-1:0];
  endfunction

  function automatic void predict_word(sample_t it);
    result_t r;
    logic [abld_pkg::OUT_W-1:0] m;
    advance_lane(0, it.pv, it, r);
    advance_lane(1, it.bv, it, r);
    if (phase_q == abld_pkg::FS_IDLE && (it.pv || it.bv)) begin
      m = it.pv ? mag_q[0] : mag_q[1];
      if (m > thr_q) begin
        if (hits < abld_pkg::EXCEED_MAX) hits++;
        if (hits >= conf_q) begin
          phase_q = abld_pkg::FS_ASCEND;
          hits = 0;
          launches++;
        end
      end
    end
    r.pmag = mag_q[0];
    r.bmag = mag_q[1];
    r.pcal = calibrated[0];
    r.bcal = calibrated[1];
    r.fs = phase_q;
    expected_results.push_back(r);
  endfunction

  function automatic bit same_result(result_t e, result_t a);
    for (int k = 0; k < 6; k++)
      if (e.axis_out[k] !== a.axis_out[k]) return 1'b0;
    return (e.pmag === a.pmag) && (e.bmag === a.bmag) && (e.pcal === a.pcal) &&
           (e.bcal === a.bcal) && (e.fs === a.fs);
  endfunction

  function automatic void clear_predictor();
    thr_q = abld_pkg::THR_RESET;
    conf_q = abld_pkg::CONF_RESET;
    cal_q = abld_pkg::CAL_RESET;
    for (int k = 0; k < 6; k++) bias_acc[k] = 0;
    n_summed = '{0, 0};
    calibrated = '{0, 0};
    mag_q = '{'0, '0};
    hits = 0;
    phase_q = abld_pkg::FS_IDLE;
  endfunction

  function automatic int unsigned random_gap(int unsigned ceil);
    if (ceil == 0) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 8);
    return $urandom_range(ceil);
  endfunction

  // driver: presents pending words, changes inputs on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_seen) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t it;
          it = pending_samples.pop_front();
          predict_word(it);
          s_axis_tdata <= DW'({it.ax[5], it.ax[4], it.ax[3],
                               it.ax[2], it.ax[1], it.ax[0]});
          s_axis_tuser <= {it.bv, it.pv};
          s_axis_tvalid <= 1'b1;
          gap_left = random_gap(max_gap);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(3) != 0) || (max_gap == 0);
    end
  end

  // handshake seen at the rising edge, consumed by the driver at the next falling edge
  always @(posedge clk_i) begin
    s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) words_in++;
  end

  // monitor: checks each result word against the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    result_t a;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        for (int k = 0; k < 6; k++)
          a.axis_out[k] = m_axis_tdata[k*abld_pkg::OUT_W +: abld_pkg::OUT_W];
        a.pmag = m_axis_tdata[6*abld_pkg::OUT_W +: abld_pkg::OUT_W];
        a.bmag = m_axis_tdata[7*abld_pkg::OUT_W +: abld_pkg::OUT_W];
        a.pcal = m_axis_tuser[0];
        a.bcal = m_axis_tuser[1];
        a.fs = abld_pkg::flight_e'(m_axis_tuser[3:2]);
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %0d", words_out);
        end else begin
          e = expected_results.pop_front();
          if (!same_result(e, a)) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result word %0d", words_out);
              for (int k = 0; k < 6; k++)
                $display("  axis%0d exp %h got %h", k, e.axis_out[k], a.axis_out[k]);
              $display("  mag exp %h/%h got %h/%h  cal exp %b%b got %b%b  state exp %s got %0d",
                       e.pmag, e.bmag, a.pmag, a.bmag, e.pcal, e.bcal, a.pcal, a.bcal,
                       e.fs.name(), a.fs);
            end
          end
        end
      end
    end
  end

  // watchdog: ends the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [SW-1:0] pick_axis(int unsigned mode);
    case (mode)
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($urandom_range(600) - 300);
      default: return SW'($urandom());
    endcase
  endfunction

  // queues one word; mode picks the axis value style
  function automatic void queue_sample(logic pv, logic bv, int unsigned mode);
    sample_t it;
    it.pv = pv;
    it.bv = bv;
    for (int k = 0; k < 6; k++)
      it.ax[k] = (mode > 3) ? pick_axis($urandom_range(3)) : pick_axis(mode);
    pending_samples.push_back(it);
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // register write, only while the block has nothing in flight
  task automatic write_reg(logic [abld_pkg::IDX_W-1:0] idx, logic [abld_pkg::THR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      abld_pkg::REG_THRESHOLD: thr_q = val;
      abld_pkg::REG_CONFIRM:   conf_q = val[abld_pkg::CONF_W-1:0];
      abld_pkg::REG_CALIB:     cal_q = val[abld_pkg::CAL_W-1:0];
      default: ;
    endcase
  endtask

  int unsigned phases_run = 0;
  initial begin
    int unsigned n;
    clear_predictor();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, invalid sensors, bias word, short calibration
    write_reg(abld_pkg::REG_CALIB, abld_pkg::THR_W'(2));
    write_reg(abld_pkg::REG_CONFIRM, abld_pkg::THR_W'(0));   // fires on first exceedance
    queue_sample(1'b0, 1'b0, 2);              // neither valid
    queue_sample(1'b1, 1'b0, 0);              // primary summing, extremes
    queue_sample(1'b0, 1'b1, 1);
    queue_sample(1'b1, 1'b1, 1);
    queue_sample(1'b1, 1'b1, 2);              // bias word on both lanes
    queue_sample(1'b1, 1'b1, 0);              // first calibrated word on both lanes
    queue_sample(1'b1, 1'b1, 0);
    queue_sample(1'b1, 1'b1, 1);
    queue_sample(1'b0, 1'b1, 3);
    queue_sample(1'b1, 1'b0, 3);
    drain();
    phases_run++;

    // random phases; calibration is already done, so only the threshold and confirm writes take effect
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(abld_pkg::REG_THRESHOLD, '1);
          write_reg(abld_pkg::REG_CONFIRM, abld_pkg::THR_W'(15));
        end
        1: begin
          write_reg(abld_pkg::REG_THRESHOLD, '0);
          write_reg(abld_pkg::REG_CALIB, abld_pkg::THR_W'(31));
        end
        2: begin
          write_reg(abld_pkg::REG_THRESHOLD, abld_pkg::THR_W'($urandom_range(2000, 100)));
          write_reg(abld_pkg::REG_CALIB, abld_pkg::THR_W'(0));
        end
        3: write_reg(abld_pkg::REG_CONFIRM, abld_pkg::THR_W'(1));
        4: write_reg(abld_pkg::REG_THRESHOLD,
                     abld_pkg::THR_W'($urandom_range(abld_pkg::THR_RESET)));
        default: write_reg(abld_pkg::REG_CALIB, abld_pkg::THR_W'($urandom_range(31)));
      endcase
      max_gap = (p == 3) ? 0 : $urandom_range(6);
      n = 250;
      for (int i = 0; i < n; i++)
        queue_sample($urandom_range(7) != 0, $urandom_range(7) != 0,
                     ($urandom_range(3) == 0) ? 4 : 2);
      drain();
      phases_run++;
    end

    $display("run covered %0d phases, %0d words in, %0d results out, %0d launch events",
             phases_run, words_in, words_out, launches);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
